// ===== sv/bpab_pkg.sv =====
// Package for the bitmap pixel unpack and alpha blend block.
// Holds the shared constants, format and register codes, and stage structs.
// No dependencies.
package bpab_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 24;
    localparam int PIXEL_W = 32;
    localparam int SUM_W   = 16;
    localparam int PROD_W  = 32;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FMT_32BPP = 2'd0;
    localparam logic [1:0] FMT_24BPP = 2'd1;
    localparam logic [1:0] FMT_8BPP  = 2'd2;
    localparam logic [1:0] FMT_4BPP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 2'd2;

    localparam logic OP_CONVERT       = 1'b0;
    localparam logic OP_PALETTE_WRITE = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_MAX   = 8'hFF;
    localparam logic [CHAN_W-1:0] OPAQUE      = 8'hFF;
    localparam logic [SUM_W-1:0]  ROUND_BIAS  = 16'd127;
    localparam logic [PROD_W-1:0] RECIP_255   = 32'd32897;
    localparam int                RECIP_SHIFT = 23;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] fg;
    } lookup_out_t;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] color;
    } blend_out_t;

endpackage

// ===== sv/bpab_lookup.sv =====
// First pipeline stage: pixel unpack and palette memory access.
// Depends on bpab_pkg.
module bpab_lookup (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic                              operation,
    input  logic [bpab_pkg::PIXEL_W-1:0]      pixel_bytes,
    input  logic                              nibble_select,
    input  logic [7:0]                        palette_index,
    input  logic [bpab_pkg::COLOR_W-1:0]      palette_color,
    input  logic [1:0]                        pixel_format,
    output bpab_pkg::lookup_out_t             out
);

    logic [bpab_pkg::COLOR_W-1:0] palette_mem [bpab_pkg::PALETTE_DEPTH];

    logic [7:0]                   rd_index;
    logic                         direct;
    logic                         rd_oob;
    logic                         wr_oob;

    logic                         valid_reg;
    logic [bpab_pkg::COLOR_W-1:0] bytes_reg;
    logic [bpab_pkg::COLOR_W-1:0] rd_data_reg;
    logic                         direct_reg;
    logic                         oob_reg;

    always_comb
    begin
        rd_index = 8'd0;
        direct   = 1'b0;
        unique case (pixel_format)
            bpab_pkg::FMT_32BPP, bpab_pkg::FMT_24BPP:
            begin
                direct = 1'b1;
            end
            bpab_pkg::FMT_8BPP:
            begin
                rd_index = pixel_bytes[7:0];
            end
            default:
            begin
                rd_index = nibble_select ? {4'd0, pixel_bytes[3:0]} : {4'd0, pixel_bytes[7:4]};
            end
        endcase
        rd_oob = {1'b0, rd_index} >= 9'(bpab_pkg::PALETTE_DEPTH);
        wr_oob = {1'b0, palette_index} >= 9'(bpab_pkg::PALETTE_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid && operation == bpab_pkg::OP_PALETTE_WRITE && !wr_oob)
        begin
            palette_mem[palette_index[bpab_pkg::PAL_ADDR_W-1:0]] <= palette_color;
        end
        if (en)
        begin
            rd_data_reg <= palette_mem[rd_index[bpab_pkg::PAL_ADDR_W-1:0]];
            bytes_reg   <= pixel_bytes[bpab_pkg::COLOR_W-1:0];
            direct_reg  <= direct;
            oob_reg     <= rd_oob;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid && operation == bpab_pkg::OP_CONVERT;
        end
    end

    assign out.valid = valid_reg;
    assign out.fg    = direct_reg ? bytes_reg
                     : (oob_reg ? '0 : rd_data_reg);

endmodule

// ===== sv/bpab_blend.sv =====
// Second and third pipeline stages: weighted channel sums, then division by 255
// through a reciprocal multiply. Depends on bpab_pkg.
module bpab_blend (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  bpab_pkg::lookup_out_t        in,
    input  logic [bpab_pkg::CHAN_W-1:0]  blend_alpha,
    input  logic [bpab_pkg::COLOR_W-1:0] background_color,
    output bpab_pkg::blend_out_t         out
);

    logic [2:0][bpab_pkg::SUM_W-1:0]  sum_next;
    logic [2:0][bpab_pkg::SUM_W-1:0]  sum_reg;
    logic [2:0][bpab_pkg::PROD_W-1:0] prod;
    logic [2:0][bpab_pkg::CHAN_W-1:0] chan_next;
    logic [2:0][bpab_pkg::CHAN_W-1:0] chan_reg;
    logic [bpab_pkg::CHAN_W-1:0]      inv_alpha;
    logic                             sum_valid_reg;
    logic                             chan_valid_reg;

    assign inv_alpha = bpab_pkg::ALPHA_MAX - blend_alpha;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = 16'(in.fg[c*8 +: 8]) * 16'(blend_alpha)
                        + 16'(background_color[c*8 +: 8]) * 16'(inv_alpha)
                        + bpab_pkg::ROUND_BIAS;
            prod[c]      = 32'(sum_reg[c]) * bpab_pkg::RECIP_255;
            chan_next[c] = prod[c][bpab_pkg::RECIP_SHIFT +: bpab_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            chan_reg <= chan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            chan_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_valid_reg  <= in.valid;
            chan_valid_reg <= sum_valid_reg;
        end
    end

    assign out.valid = chan_valid_reg;
    assign out.color = chan_reg;

endmodule

// ===== sv/bpab_skid.sv =====
// Output register with one skid entry, so the upstream ready is a register.
// Depends on bpab_pkg.
module bpab_skid (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [bpab_pkg::PIXEL_W-1:0] in_data,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bpab_pkg::PIXEL_W-1:0] out_data
);

    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    logic [bpab_pkg::PIXEL_W-1:0] out_data_reg;
    logic [bpab_pkg::PIXEL_W-1:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry is full while the output register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> !skid_valid_reg)
        else $error("Skid entry was not drained after the output beat was taken.");

endmodule

// ===== sv/bmp_pixel_unpack_alpha_blend.sv =====
// Bitmap pixel unpack with palette lookup and constant-alpha blend.
// Lookup, sum, channel and output registers; one beat per cycle while s_tready is high.
// s_tready is low only while the output skid entry holds a beat; that register sets the rate.
// Palette-write beats give no output beat. Reset clears the configuration registers and
// all valid bits; palette contents are undefined until written, with no clearing pass.
module bmp_pixel_unpack_alpha_blend (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bpab_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [bpab_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: pixel_bytes[31:0], nibble_select[32], palette_index[40:33],
    // palette_color[64:41], zero padding[71:65]
    input  logic [71:0]                      s_tdata,
    // tuser: operation[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: blended_color[31:0]
    output logic [31:0]                      m_tdata
);

    logic [1:0]                   pixel_format_reg;
    logic [bpab_pkg::CHAN_W-1:0]  blend_alpha_reg;
    logic [bpab_pkg::COLOR_W-1:0] background_color_reg;

    logic                         en;
    bpab_pkg::lookup_out_t        s1;
    bpab_pkg::blend_out_t         s3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg     <= bpab_pkg::FMT_32BPP;
            blend_alpha_reg      <= '0;
            background_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bpab_pkg::CFG_PIXEL_FORMAT:     pixel_format_reg     <= cfg_wdata[1:0];
                bpab_pkg::CFG_BLEND_ALPHA:      blend_alpha_reg      <= cfg_wdata[7:0];
                bpab_pkg::CFG_BACKGROUND_COLOR: background_color_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = en;

    bpab_lookup u_lookup (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .operation     (s_tuser),
        .pixel_bytes   (s_tdata[31:0]),
        .nibble_select (s_tdata[32]),
        .palette_index (s_tdata[40:33]),
        .palette_color (s_tdata[64:41]),
        .pixel_format  (pixel_format_reg),
        .out           (s1)
    );

    bpab_blend u_blend (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in               (s1),
        .blend_alpha      (blend_alpha_reg),
        .background_color (background_color_reg),
        .out              (s3)
    );

    bpab_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3.valid),
        .in_data   ({bpab_pkg::OPAQUE, s3.color}),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == bpab_pkg::OP_PALETTE_WRITE) |=> !s1.valid)
        else $error("A palette write beat entered the pixel pipeline.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == bpab_pkg::OP_CONVERT) |=> s1.valid)
        else $error("An accepted pixel beat was lost at the lookup stage.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] == bpab_pkg::OPAQUE)
        else $error("Output beat is not opaque.");

endmodule

// ===== bench/tb_bmp_pixel_unpack_alpha_blend.sv =====
// Testbench for bmp_pixel_unpack_alpha_blend: directed and random pixel and palette beats
// with bursty input, stalling output and a predictor of the unpack and blend in this module.
// Depends on bpab_pkg and the block's RTL only.
module tb_bmp_pixel_unpack_alpha_blend;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE_WAIT = 8;

    typedef struct {
        logic        op;
        logic [31:0] bytes;
        logic        nsel;
        logic [7:0]  pidx;
        logic [23:0] pcol;
        bit          drain_first;
    } pixel_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = 2'd0;
    logic [23:0] cfg_wdata = 24'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = 72'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    pixel_item_t pixels_to_send[$];
    logic [31:0] expected_colors[$];
    pixel_item_t sent_pixel;
    pixel_item_t head_pixel;
    logic [31:0] wanted_color;

    logic [1:0]  fmt_now = bpab_pkg::FMT_32BPP;
    logic [7:0]  alpha_now = 8'd0;
    logic [23:0] bg_now = 24'd0;
    logic [23:0] palette_model[256];

    bit          palette_seen[256];
    int unsigned seen_all[$];
    int unsigned seen_low[$];
    bit          hold_next = 1'b0;

    int          send_mode = 0;
    int          recv_mode = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    bmp_pixel_unpack_alpha_blend uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] weigh_channel(input logic [7:0] fg, input logic [7:0] bk,
                                                 input logic [7:0] a);
        int unsigned fi;
        int unsigned bi;
        int unsigned ai;
        fi = fg;
        bi = bk;
        ai = a;
        return 8'((fi * ai + bi * (255 - ai) + 127) / 255);
    endfunction

    function automatic logic [31:0] blended_pixel(input pixel_item_t it);
        logic [23:0] fg;
        unique case (fmt_now)
            bpab_pkg::FMT_32BPP, bpab_pkg::FMT_24BPP: fg = it.bytes[23:0];
            bpab_pkg::FMT_8BPP:  fg = palette_model[it.bytes[7:0]];
            default:             fg = palette_model[{4'd0, it.nsel ? it.bytes[3:0]
                                                                   : it.bytes[7:4]}];
        endcase
        return {bpab_pkg::OPAQUE,
                weigh_channel(fg[23:16], bg_now[23:16], alpha_now),
                weigh_channel(fg[15:8], bg_now[15:8], alpha_now),
                weigh_channel(fg[7:0], bg_now[7:0], alpha_now)};
    endfunction

    // Sender: beats come from the pending queue; the prediction is made when a beat is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sent_pixel = pixels_to_send.pop_front();
                if (sent_pixel.op == bpab_pkg::OP_PALETTE_WRITE)
                begin
                    palette_model[sent_pixel.pidx] = sent_pixel.pcol;
                end
                else
                begin
                    expected_colors.push_back(blended_pixel(sent_pixel));
                end
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pixels_to_send.size() != 0)
                begin
                    head_pixel = pixels_to_send[0];
                    if (head_pixel.drain_first && expected_colors.size() != 0)
                    begin
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_tvalid <= 1'b1;
                        s_tuser <= head_pixel.op;
                        s_tdata <= {7'd0, head_pixel.pcol, head_pixel.pidx, head_pixel.nsel,
                                    head_pixel.bytes};
                        if (send_mode != 0)
                        begin
                            burst_left = burst_left - 1;
                            if (burst_left <= 0)
                            begin
                                burst_left = (send_mode == 1) ? $urandom_range(1, 16)
                                                              : $urandom_range(1, 3);
                                gap_left = $urandom_range(0, (send_mode == 1) ? 8 : 3);
                            end
                        end
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        unique case (recv_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) >= 3);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left = stall_left - 1;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(1, 24);
                    end
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("blended_color: no beat expected, actual %h", m_tdata);
                mismatches = mismatches + 1;
            end
            else
            begin
                wanted_color = expected_colors.pop_front();
                if (m_tdata !== wanted_color)
                begin
                    $error("blended_color: expected %h, actual %h", wanted_color, m_tdata);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic settle();
        while (pixels_to_send.size() != 0 || expected_colors.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Upper data bits are junk on purpose; each register keeps only its own width.
    task automatic begin_phase(input logic [1:0] fmt, input logic [7:0] alpha,
                               input logic [23:0] bg, input int smode, input int rmode);
        logic [31:0] junk;
        junk = $urandom;
        settle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= bpab_pkg::CFG_PIXEL_FORMAT;
        cfg_wdata <= {junk[21:0], fmt};
        @(posedge clk);
        cfg_addr <= bpab_pkg::CFG_BLEND_ALPHA;
        cfg_wdata <= {junk[31:16], alpha};
        @(posedge clk);
        cfg_addr <= bpab_pkg::CFG_BACKGROUND_COLOR;
        cfg_wdata <= bg;
        @(posedge clk);
        cfg_addr <= CFG_SPARE;
        cfg_wdata <= ~junk[23:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        fmt_now = fmt;
        alpha_now = alpha;
        bg_now = bg;
        @(negedge clk);
        send_mode = smode;
        recv_mode = rmode;
        burst_left = 1;
        gap_left = 0;
    endtask

    task automatic queue_palette(input logic [7:0] idx, input logic [23:0] color);
        pixel_item_t it;
        it.op = bpab_pkg::OP_PALETTE_WRITE;
        it.bytes = $urandom;
        it.nsel = 1'($urandom_range(0, 1));
        it.pidx = idx;
        it.pcol = color;
        it.drain_first = hold_next;
        hold_next = 1'b0;
        pixels_to_send.push_back(it);
        if (!palette_seen[idx])
        begin
            palette_seen[idx] = 1'b1;
            seen_all.push_back(32'(idx));
            if (idx < 16)
            begin
                seen_low.push_back(32'(idx));
            end
        end
    endtask

    task automatic queue_convert(input logic [31:0] bytes, input logic nsel);
        pixel_item_t it;
        logic [31:0] junk;
        junk = $urandom;
        it.op = bpab_pkg::OP_CONVERT;
        it.bytes = bytes;
        it.nsel = nsel;
        it.pidx = junk[7:0];
        it.pcol = junk[31:8];
        it.drain_first = hold_next;
        hold_next = 1'b0;
        pixels_to_send.push_back(it);
    endtask

    // Indexed formats only read palette entries that an earlier beat has written.
    task automatic queue_random_beat(input logic [1:0] fmt);
        int unsigned roll;
        int unsigned idx;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        raw = $urandom;
        if (roll < 12 || (fmt == bpab_pkg::FMT_8BPP && seen_all.size() == 0) ||
            (fmt == bpab_pkg::FMT_4BPP && seen_low.size() == 0))
        begin
            idx = roll[0] ? $urandom_range(0, 15) : $urandom_range(0, 255);
            queue_palette(idx[7:0], (roll < 3) ? 24'hFFFFFF : raw[23:0]);
        end
        else if (fmt == bpab_pkg::FMT_8BPP)
        begin
            idx = seen_all[$urandom_range(0, seen_all.size() - 1)];
            raw[7:0] = idx[7:0];
            queue_convert(raw, 1'($urandom_range(0, 1)));
        end
        else if (fmt == bpab_pkg::FMT_4BPP)
        begin
            idx = seen_low[$urandom_range(0, seen_low.size() - 1)];
            if (roll[0])
            begin
                raw[3:0] = idx[3:0];
                queue_convert(raw, 1'b1);
            end
            else
            begin
                raw[7:4] = idx[3:0];
                queue_convert(raw, 1'b0);
            end
        end
        else
        begin
            if (roll < 18)
            begin
                raw = roll[0] ? 32'hFFFFFFFF : 32'h00000000;
            end
            queue_convert(raw, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [1:0]  fmt;
        logic [7:0]  alpha;
        logic [23:0] bg;
        int          drain_at;
        logic [31:0] junk;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Direct color formats: full pixel, then background only; source alpha byte ignored.
        begin_phase(bpab_pkg::FMT_32BPP, 8'd255, 24'h000000, 0, 0);
        queue_convert(32'h00000000, 1'b0);
        queue_convert(32'hFFFFFFFF, 1'b1);
        queue_convert(32'hA5123456, 1'b0);
        begin_phase(bpab_pkg::FMT_24BPP, 8'd0, 24'hFFFFFF, 1, 1);
        queue_convert(32'hFFABCDEF, 1'b1);
        queue_convert(32'h00000000, 1'b0);

        // Palette writes give no beat; a write followed at once by a read of that entry.
        begin_phase(bpab_pkg::FMT_8BPP, 8'd128, 24'h102030, 2, 2);
        queue_palette(8'd0, 24'hFFFFFF);
        queue_palette(8'd255, 24'h000000);
        queue_palette(8'd15, 24'h123456);
        junk = $urandom;
        queue_convert({junk[31:8], 8'd0}, 1'b1);
        queue_convert({24'hFFFFFF, 8'd255}, 1'b0);
        queue_convert({junk[23:0], 8'd15}, 1'b0);
        queue_palette(8'd7, 24'hABCDEF);
        queue_convert({junk[31:8], 8'd7}, 1'b1);

        begin_phase(bpab_pkg::FMT_4BPP, 8'd1, 24'hFFFFFF, 1, 0);
        junk = $urandom;
        queue_convert({junk[31:8], 8'hF0}, 1'b0);
        queue_convert({junk[31:8], 8'hF0}, 1'b1);
        queue_convert({24'hFFFFFF, 8'h0F}, 1'b0);
        queue_convert({24'h000000, 8'h0F}, 1'b1);
        queue_convert({junk[23:0], 8'h7F}, 1'b0);

        for (int p = 0; p < 10; p++)
        begin
            fmt = (p < 8) ? 2'(p % 4) : 2'($urandom_range(0, 3));
            unique case (p % 5)
                0:       alpha = 8'd255;
                1:       alpha = 8'd0;
                default: alpha = 8'($urandom_range(0, 255));
            endcase
            unique case (p % 3)
                0:       bg = 24'hFFFFFF;
                1:       bg = 24'h000000;
                default: bg = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            begin_phase(fmt, alpha, bg, p % 3, (p / 3) % 3);
            drain_at = $urandom_range(10, 65);
            for (int n = 0; n < 75; n++)
            begin
                if (n == drain_at)
                begin
                    hold_next = 1'b1;
                end
                queue_random_beat(fmt);
            end
        end

        settle();
        if (mismatches == 0 && expected_colors.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
